// ===== rtl/bbs_pkg.sv =====
package bbs_pkg;

    localparam int DEF_MOD_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0]  REG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_SEED    = 1'd1;

    localparam logic [FIELD_W-1:0] MODULUS_RST = 32'd3;
    localparam logic [FIELD_W-1:0] SEED_RST    = 32'd2;

    typedef struct packed {
        logic reseed;
    } t_req;

    typedef struct packed {
        logic               random_bit;
        logic [FIELD_W-1:0] state_value;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic reduce_step;
        logic sq_init;
        logic sq_from_rem;
        logic dbl_step;
        logic add_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic n_small;
        logic x_below_n;
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/bbs_stream_if.sv =====
interface bbs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bbs_datapath.sv =====
module bbs_datapath
    import bbs_pkg::*;
#(
    parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_reseed,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_rsp                  o_out_data
);
    localparam int W   = MOD_WIDTH;
    localparam int CW  = $clog2(W);
    localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

    logic [W-1:0]  r_mod;
    logic [W-1:0]  r_seed;
    logic [W-1:0]  r_state;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    t_rsp          r_out;

    logic [W:0]    n_rem_sum;
    logic [W:0]    n_rem_sub;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  n_addend;
    logic [W:0]    n_sum;
    logic [W:0]    n_sum_sub;
    logic [W-1:0]  n_acc_mod;
    logic          n_out_free;

    // shift one bit of x into the remainder, subtract modulus when it fits
    assign n_rem_sum = {r_rem, r_x[W-1]};
    assign n_rem_sub = n_rem_sum - {1'b0, r_mod};
    assign n_rem     = (n_rem_sum >= {1'b0, r_mod}) ? n_rem_sub[W-1:0] : n_rem_sum[W-1:0];

    // modular add: acc + acc on doubling, acc + a on add
    assign n_addend  = i_cmd.dbl_step ? r_acc : r_a;
    assign n_sum     = {1'b0, r_acc} + {1'b0, n_addend};
    assign n_sum_sub = n_sum - {1'b0, r_mod};
    assign n_acc_mod = (n_sum >= {1'b0, r_mod}) ? n_sum_sub[W-1:0] : n_sum[W-1:0];

    assign n_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= W'(MODULUS_RST);
            r_seed      <= W'(SEED_RST);
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODULUS: r_mod  <= W'(i_cfg_data);
                    REG_SEED:    r_seed <= W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_state     <= r_acc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_reseed ? r_seed : r_state;
            r_rem <= '0;
            r_cnt <= CNT_TOP;
        end
        if (i_cmd.reduce_step) begin
            r_rem <= n_rem;
            r_x   <= {r_x[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.sq_init) begin
            r_a   <= i_cmd.sq_from_rem ? r_rem : r_x;
            r_x   <= i_cmd.sq_from_rem ? r_rem : r_x;
            r_acc <= '0;
            r_cnt <= CNT_TOP;
        end
        if (i_cmd.dbl_step) begin
            r_acc <= n_acc_mod;
        end
        if (i_cmd.add_step) begin
            if (r_x[W-1]) begin
                r_acc <= n_acc_mod;
            end
            r_x   <= {r_x[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.commit) begin
            r_out.random_bit  <= r_acc[0];
            r_out.state_value <= FIELD_W'(r_acc);
        end
    end

    assign o_status.n_small   = (r_mod < W'(2));
    assign o_status.x_below_n = (r_x < r_mod);
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.out_free  = n_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== rtl/bbs_controller.sv =====
module bbs_controller
    import bbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_REDUCE = 7'b0000100,
        S_SQINIT = 7'b0001000,
        S_DOUBLE = 7'b0010000,
        S_ADD    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                if (i_status.n_small) begin
                    o_cmd.sq_init = 1'b1;
                    n_state       = S_DONE;
                end else if (i_status.x_below_n) begin
                    o_cmd.sq_init = 1'b1;
                    n_state       = S_DOUBLE;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce_step = 1'b1;
                if (i_status.cnt_zero) begin
                    n_state = S_SQINIT;
                end
            end
            S_SQINIT: begin
                o_cmd.sq_init     = 1'b1;
                o_cmd.sq_from_rem = 1'b1;
                n_state           = S_DOUBLE;
            end
            S_DOUBLE: begin
                o_cmd.dbl_step = 1'b1;
                n_state        = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_step = 1'b1;
                n_state        = i_status.cnt_zero ? S_DONE : S_DOUBLE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/bbs_bit_generator_top.sv =====
// Blum Blum Shub bit generator.
// i_req carries one transaction per step: reseed = 1 loads the state with
// seed squared mod N, reseed = 0 squares the current state mod N.
// o_rsp returns one transaction per request: the new state and its low bit.
// The modulus (index 0) and seed (index 1) are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while no request
// is in flight, as the block itself does not enforce it. When the source
// value is below the modulus, the squaring runs on it directly; otherwise
// it is first reduced mod N, one remainder bit per cycle. A modulus
// below two gives a zero result without squaring.
// The squaring is a shift-and-add modular multiply: a doubling step and
// an add step per operand bit through a single adder and compare.
// Requests are taken one at a time; i_req.ready rises again once the result
// is in the output register, so a new request can start while o_rsp stalls.
// If the previous result is still unclaimed when a new one completes, the
// block holds in its final state until o_rsp.ready frees the register.
// Reset: modulus 3, seed 2, state 0, no result pending.
module bbs_bit_generator_top
    import bbs_pkg::*;
#(
    parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bbs_stream_if.sink            i_req,
    bbs_stream_if.source          o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cmd    cmd;
    t_status status;
    t_req    req_data;
    t_rsp    rsp_data;
    logic    in_ready;
    logic    out_valid;

    assign req_data    = i_req.data;
    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp_data;

    bbs_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bbs_datapath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_reseed    (req_data.reseed),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_out_data  (rsp_data)
    );
endmodule
